// ===== design/bprm_pkg.sv =====
package bprm_pkg;

    // Sample and level format: signed Q1.23 in, unsigned Q1.23 out
    localparam int SAMPLE_BITS = 24;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int SUM_W       = 58;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int ITER_W      = $clog2(SUM_W);

    localparam logic [SAMPLE_BITS-1:0] LEVEL_ONE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_END  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

endpackage

// ===== design/block_peak_rms_meter_top.sv =====
// Sequence: a counted sample beat is accepted, squared, then accumulated; an ignored or
// dropped sample is only accepted. An end-of-buffer beat then adds the end, divide, root and
// output states, worked serially on the one shared subtractor; if empty, the end state only.
// Throughput: the result waits in an output register and the next beat is taken while it is
// held; a second result stalls in the output state until the first one has been taken.
// Reset: rst_n is asynchronous, active low; clears sums, peak and count, accept_samples = 1.
module block_peak_rms_meter_top
    import bprm_pkg::*;
#(
    parameter int MAX_BUFFER_SAMPLES = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: accept_samples
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] s_tdata,   // [23:0] sample
    input  logic                   s_tuser,   // [0] has_sample
    input  logic                   s_tlast,   // end_of_buffer
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*SAMPLE_BITS-1:0] m_tdata, // [23:0] rms_level, [47:24] peak_level
    output logic                   m_tuser    // [0] truncated
);

    localparam int CNT_W = $clog2(MAX_BUFFER_SAMPLES + 1);
    localparam int ALU_W = (CNT_W + 1 > ROOT_W + 3) ? CNT_W + 1 : ROOT_W + 3;

    // control state
    state_t               state_reg, state_next;
    logic                 accept_reg, accept_next;
    logic                 eob_reg, eob_next;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic                 mvalid_reg, mvalid_next;

    // datapath
    logic [SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic [SUM_W-1:0]     work_reg, work_next;
    logic [ALU_W-1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [SAMPLE_BITS-1:0] rms_out_reg, rms_out_next;
    logic [SAMPLE_BITS-1:0] peak_out_reg, peak_out_next;
    logic                 trunc_out_reg, trunc_out_next;

    // shared subtractor
    logic [ALU_W-1:0]     alu_a, alu_b;
    logic [ALU_W:0]       alu_diff;
    logic                 alu_ge;

    logic                 s_fire, m_fire, full, take;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SUM_W:0]       acc_sum;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = mvalid_reg && m_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {peak_out_reg, rms_out_reg};
    assign m_tuser  = trunc_out_reg;

    assign raw     = s_tdata;
    assign full    = (count_reg >= CNT_W'(MAX_BUFFER_SAMPLES));
    assign take    = s_tuser && accept_reg && !full;
    assign acc_sum = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);

    // pick operands: divide step in S_DIV, root step otherwise
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            alu_a = ALU_W'({rem_reg[CNT_W-1:0], work_reg[SUM_W-1]});
            alu_b = ALU_W'(count_reg);
        end
        else
        begin
            alu_a = ALU_W'({rem_reg[ROOT_W:0], work_reg[SUM_W-1:SUM_W-2]});
            alu_b = ALU_W'({root_reg, 2'b01});
        end
        alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
        alu_ge   = !alu_diff[ALU_W];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        accept_next    = cfg_we ? cfg_wdata : accept_reg;
        eob_next       = eob_reg;
        peak_next      = peak_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        iter_next      = iter_reg;
        mvalid_next    = m_fire ? 1'b0 : mvalid_reg;
        mag_next       = mag_reg;
        sq_next        = sq_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        rms_out_next   = rms_out_reg;
        peak_out_next  = peak_out_reg;
        trunc_out_next = trunc_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    eob_next = s_tlast;
                    mag_next = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
                    if (s_tuser && accept_reg && full)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (take)
                    begin
                        state_next = S_MUL;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_END;
                    end
                end
            end
            S_MUL:
            begin
                // square the magnitude, track the peak, count the sample
                sq_next    = SQ_W'(mag_reg) * SQ_W'(mag_reg);
                if (mag_reg > peak_reg)
                begin
                    peak_next = mag_reg;
                end
                count_next = count_reg + 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // saturate the sum instead of wrapping
                sum_next   = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
                state_next = eob_reg ? S_END : S_IDLE;
            end
            S_END:
            begin
                if (count_reg == '0)
                begin
                    peak_next  = '0;
                    sum_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    work_next  = sum_reg;
                    rem_next   = '0;
                    iter_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // one quotient bit per cycle, quotient shifts into work
                if (alu_ge)
                begin
                    rem_next = ALU_W'(alu_diff[CNT_W-1:0]);
                end
                else
                begin
                    rem_next = ALU_W'({rem_reg[CNT_W-2:0], work_reg[SUM_W-1]});
                end
                work_next = {work_reg[SUM_W-2:0], alu_ge};
                if (iter_reg == ITER_W'(SUM_W - 1))
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                // one root bit per cycle, two radicand bits consumed
                if (alu_ge)
                begin
                    rem_next = ALU_W'(alu_diff[ROOT_W:0]);
                end
                else
                begin
                    rem_next = ALU_W'(alu_a[ROOT_W:0]);
                end
                root_next = {root_reg[ROOT_W-2:0], alu_ge};
                work_next = {work_reg[SUM_W-3:0], 2'b00};
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free, then load and clear
                if (!mvalid_reg || m_tready)
                begin
                    if (root_reg > ROOT_W'(LEVEL_ONE))
                    begin
                        rms_out_next = LEVEL_ONE;
                    end
                    else
                    begin
                        rms_out_next = root_reg[SAMPLE_BITS-1:0];
                    end
                    peak_out_next  = (peak_reg > LEVEL_ONE) ? LEVEL_ONE : peak_reg;
                    trunc_out_next = ovf_reg;
                    mvalid_next    = 1'b1;
                    peak_next      = '0;
                    sum_next       = '0;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            accept_reg <= 1'b1;
            eob_reg    <= 1'b0;
            peak_reg   <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            iter_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            accept_reg <= accept_next;
            eob_reg    <= eob_next;
            peak_reg   <= peak_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            iter_reg   <= iter_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        sq_reg        <= sq_next;
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        rms_out_reg   <= rms_out_next;
        peak_out_reg  <= peak_out_next;
        trunc_out_reg <= trunc_out_next;
    end

endmodule
